@@ design/plm_pkg.sv @@
// ----------------------------------------------------------------------------
// plm_pkg: shared types and codes for the positional list engine
// Holds the operation codes, result status codes and the command that is
// broadcast to every cell of the shifting row.
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

	// Requested operation on an input transfer.
	typedef enum logic [2:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_POS   = 3'd2,
		MODE_DEL_FRONT = 3'd3,
		MODE_DEL_BACK  = 3'd4,
		MODE_DEL_POS   = 3'd5,
		MODE_DUMP      = 3'd6,
		MODE_COUNT     = 3'd7
	} mode_t;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// What every cell does on a broadcast command.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage : plm_pkg

`default_nettype wire

@@ design/plm_cell.sv @@
// ----------------------------------------------------------------------------
// plm_cell: one storage cell of the shifting list row
// Holds one element and, on a broadcast command, keeps it, takes the value of
// a neighbor or takes the new value, depending on its place in the row.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_cell
	import plm_pkg::*;
#(
	parameter int IDX_W = 5,
	parameter int CNT_W = 6,
	parameter int INDEX = 0
) (
	input  wire logic                      clk,
	input  wire cell_cmd_t                 cmd,
	input  wire logic        [IDX_W-1:0]   idx,
	input  wire logic        [CNT_W-1:0]   count,
	input  wire logic signed [31:0]        left,
	input  wire logic signed [31:0]        right,
	input  wire logic signed [31:0]        head,
	output logic signed      [31:0]        data
);

	localparam logic [IDX_W-1:0] MyIdx  = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MyNext = CNT_W'(INDEX + 1);

	logic signed [31:0] data_q;
	logic signed [31:0] data_d;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			CELL_INS: begin
				if (MyIdx > idx) begin
					data_d = left;
				end else if (MyIdx == idx) begin
					data_d = cmd.value;
				end
			end
			CELL_DEL: begin
				if (MyIdx >= idx) begin
					data_d = right;
				end
			end
			CELL_ROT: begin
				// The last occupied cell wraps around to the head.
				if (MyNext == count) begin
					data_d = head;
				end else if (MyNext < count) begin
					data_d = right;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule : plm_cell

`default_nettype wire

@@ design/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values in a cell row
// Timing: a status result is registered and valid in the cycle after its input
// transfer; a dump first enters the dump state, then sends its elements one per
// cycle through the output register while out_ready holds. A new input waits
// until the single output register has drained and no dump is running.
// Reset: arst_n clears the fill count, control state and output valid; the
// cell contents stay undefined and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine
	import plm_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [2:0]  mode,
	input  wire logic signed [31:0] value,
	input  wire logic        [5:0]  position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [1:0]  status,
	output logic signed      [31:0] element,
	output logic             [5:0]  element_count,
	output logic                    last
);

	// Index width addresses one cell; count width can also hold CAPACITY itself.
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// Comparison width that holds both the position field and count + 1.
	localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   remain_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic signed [31:0] element_q;
	logic [5:0]         element_count_q;
	logic               last_q;

	// Command broadcast to the cell row this cycle.
	cell_cmd_t          cmd;
	logic [IDX_W-1:0]   cell_idx;

	logic               in_fire;
	logic               out_free;
	logic               full;
	logic               empty;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic [1:0]         acc_status;
	logic [CNT_W-1:0]   count_d;
	logic               start_dump;

	logic signed [31:0] cell_data [CAPACITY];

	// Only one item is in flight: a new input is taken once the previous
	// result has been handed over and no dump is running.
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count_q);

	// Decode the accepted operation: check it, pick the cell command and the
	// count that follows. Insert positions run 1..count+1, delete 1..count.
	always_comb begin
		cmd.op     = CELL_HOLD;
		cmd.value  = value;
		cell_idx   = '0;
		acc_status = ST_OK;
		count_d    = count_q;
		start_dump = 1'b0;
		if (in_fire) begin
			unique case (mode_t'(mode))
				MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
					if (full) begin
						acc_status = ST_FULL;
					end else if ((mode_t'(mode) == MODE_INS_POS) &&
					             ((pos_x == '0) || (pos_x > cnt_x + CMP_W'(1)))) begin
						acc_status = ST_BADPOS;
					end else begin
						cmd.op  = CELL_INS;
						count_d = count_q + CNT_W'(1);
						if (mode_t'(mode) == MODE_INS_FRONT) begin
							cell_idx = '0;
						end else if (mode_t'(mode) == MODE_INS_BACK) begin
							cell_idx = IDX_W'(count_q);
						end else begin
							cell_idx = IDX_W'(position - 6'd1);
						end
					end
				end
				MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
					if (empty) begin
						acc_status = ST_EMPTY;
					end else if ((mode_t'(mode) == MODE_DEL_POS) &&
					             ((pos_x == '0) || (pos_x > cnt_x))) begin
						acc_status = ST_BADPOS;
					end else begin
						cmd.op  = CELL_DEL;
						count_d = count_q - CNT_W'(1);
						if (mode_t'(mode) == MODE_DEL_FRONT) begin
							cell_idx = '0;
						end else if (mode_t'(mode) == MODE_DEL_BACK) begin
							cell_idx = IDX_W'(count_q - CNT_W'(1));
						end else begin
							cell_idx = IDX_W'(position - 6'd1);
						end
					end
				end
				MODE_DUMP: begin
					// An empty list answers with a single status result.
					start_dump = !empty;
				end
				MODE_COUNT: begin
					acc_status = ST_OK;
				end
				default: acc_status = ST_OK;
			endcase
		end
		// During a dump the occupied cells rotate toward the head by one each
		// time an element is sent; after count steps the order is restored.
		if ((state_q == S_DUMP) && out_free) begin
			cmd.op = CELL_ROT;
		end
	end

	// Row of cells: each takes data from its left or right neighbor, and the
	// last occupied one can take the head during a rotation.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [31:0] left_in;
		logic signed [31:0] right_in;

		if (g == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_inner_l
			assign left_in = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_lastc
			assign right_in = '0;
		end else begin : g_inner_r
			assign right_in = cell_data[g+1];
		end

		plm_cell #(
			.IDX_W (IDX_W),
			.CNT_W (CNT_W),
			.INDEX (g)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (cell_idx),
			.count (count_q),
			.left  (left_in),
			.right (right_in),
			.head  (cell_data[0]),
			.data  (cell_data[g])
		);
	end

	// Control state, fill count and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			remain_q        <= '0;
			out_valid_q     <= 1'b0;
			status_q        <= ST_OK;
			element_q       <= '0;
			element_count_q <= '0;
			last_q          <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						count_q <= count_d;
						if (start_dump) begin
							state_q  <= S_DUMP;
							remain_q <= count_q;
						end else begin
							out_valid_q     <= 1'b1;
							status_q        <= acc_status;
							element_q       <= '0;
							element_count_q <= 6'(count_d);
							last_q          <= 1'b1;
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						status_q        <= ST_OK;
						element_q       <= cell_data[0];
						element_count_q <= 6'(count_q);
						last_q          <= (remain_q == CNT_W'(1));
						remain_q        <= remain_q - CNT_W'(1);
						if (remain_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign element       = element_q;
	assign element_count = element_count_q;
	assign last          = last_q;

endmodule : positional_list_engine

`default_nettype wire
